/* src/sag_pkg.sv */
// Shared types and constants for the sprite animation graph block.
// No dependencies; every other file in src but sag_ram imports it.
package sag_pkg;

    localparam int NUM_ANIMS_DEF = 8;
    localparam int NUM_CONDS_DEF = 16;

    localparam int KIND_W   = 2;
    localparam int NOW_W    = 64;
    localparam int FLAG_W   = 16;
    localparam int SEL_W    = 3;
    localparam int FRAMES_W = 8;
    localparam int PERIOD_W = 16;
    localparam int FW_W     = 12;
    localparam int X_W      = 20;
    localparam int DESC_W   = FRAMES_W + PERIOD_W + 2;
    localparam int DIV_CNT_W = $clog2(NOW_W);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET = 12'd16;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH = 1'b0
    } reg_index_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK = 2'd0,
        KIND_ANIM = 2'd1,
        KIND_EDGE = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_DECIDE,
        ST_DIV,
        ST_FOLD,
        ST_MULX,
        ST_SCAN_ISSUE,
        ST_SCAN,
        ST_DESC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic cap_tick;
        logic wr_anim;
        logic wr_edge;
        logic last_x_ld;
        logic div_init;
        logic div_step;
        logic fold;
        logic mulx;
        logic scan_start;
        logic scan_step;
        logic take_edge;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic advance;
        logic period_zero;
        logic div_last;
        logic edge_hit;
        logic scan_last;
        logic out_free;
    } ctrl_stat_t;

endpackage

/* src/sag_in_if.sv */
// Input channel of the sprite animation graph: valid/ready plus one item.
// Depends on sag_pkg for field widths.
interface sag_in_if;
    import sag_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [NOW_W-1:0]    now_ms;
    logic [FLAG_W-1:0]   cond_flags;
    logic [SEL_W-1:0]    anim_sel;
    logic [SEL_W-1:0]    target_sel;
    logic [FRAMES_W-1:0] frame_count;
    logic [PERIOD_W-1:0] frame_period;
    logic                looping;
    logic                reversible;
    logic [FLAG_W-1:0]   edge_mask;

    modport source (
        output valid, kind, now_ms, cond_flags, anim_sel, target_sel,
               frame_count, frame_period, looping, reversible, edge_mask,
        input  ready
    );

    modport sink (
        input  valid, kind, now_ms, cond_flags, anim_sel, target_sel,
               frame_count, frame_period, looping, reversible, edge_mask,
        output ready
    );
endinterface

/* src/sag_out_if.sv */
// Result channel of the sprite animation graph: valid/ready plus one item.
// Depends on sag_pkg for field widths.
interface sag_out_if;
    import sag_pkg::*;

    logic                valid;
    logic                ready;
    logic [FRAMES_W-1:0] frame_index;
    logic [X_W-1:0]      frame_x;
    logic [SEL_W-1:0]    anim_current;
    logic                switched;

    modport source (
        output valid, frame_index, frame_x, anim_current, switched,
        input  ready
    );

    modport sink (
        input  valid, frame_index, frame_x, anim_current, switched,
        output ready
    );
endinterface

/* src/sag_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/sag_ctrl.sv */
// Sequencer of the sprite animation graph: clearing pass, item decode,
// divide, frame update, edge scan and result hand-off. Depends on sag_pkg.
module sag_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [sag_pkg::KIND_W-1:0] in_kind,
    output logic                      in_ready,
    input  sag_pkg::ctrl_stat_t       stat,
    output sag_pkg::ctrl_cmd_t        cmd
);
    import sag_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && (in_kind == KIND_TICK))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!stat.advance)
                begin
                    state_next = ST_SCAN_ISSUE;
                end
                else if (stat.period_zero)
                begin
                    state_next = ST_FOLD;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                state_next = ST_MULX;
            end
            ST_MULX:
            begin
                state_next = ST_SCAN_ISSUE;
            end
            ST_SCAN_ISSUE:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (stat.edge_hit)
                begin
                    state_next = ST_DESC;
                end
                else if (stat.scan_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DESC:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_kind)
                        KIND_TICK: cmd.cap_tick = 1'b1;
                        KIND_ANIM: cmd.wr_anim  = 1'b1;
                        KIND_EDGE: cmd.wr_edge  = 1'b1;
                        default:   cmd          = '0;
                    endcase
                end
            end
            ST_PREP:
            begin
                cmd.last_x_ld = 1'b1;
            end
            ST_DECIDE:
            begin
                cmd.div_init = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
            end
            ST_MULX:
            begin
                cmd.mulx = 1'b1;
            end
            ST_SCAN_ISSUE:
            begin
                cmd.scan_start = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan_step = !stat.edge_hit && !stat.scan_last;
            end
            ST_DESC:
            begin
                cmd.take_edge = 1'b1;
            end
            ST_OUT:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule

/* src/sag_dp.sv */
// Datapath of the sprite animation graph: tables, running descriptor,
// serial divider with folded modulo, frame offset multiply, edge check.
// Depends on sag_pkg and sag_ram.
module sag_dp #(
    parameter int NUM_ANIMS = sag_pkg::NUM_ANIMS_DEF,
    parameter int NUM_CONDS = sag_pkg::NUM_CONDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sag_pkg::ctrl_cmd_t            cmd,
    output sag_pkg::ctrl_stat_t           stat,
    input  logic [sag_pkg::FW_W-1:0]      frame_width,
    input  logic [sag_pkg::NOW_W-1:0]     now_ms,
    input  logic [sag_pkg::FLAG_W-1:0]    cond_flags,
    input  logic [sag_pkg::SEL_W-1:0]     anim_sel,
    input  logic [sag_pkg::SEL_W-1:0]     target_sel,
    input  logic [sag_pkg::FRAMES_W-1:0]  frame_count,
    input  logic [sag_pkg::PERIOD_W-1:0]  frame_period,
    input  logic                          looping,
    input  logic                          reversible,
    input  logic [sag_pkg::FLAG_W-1:0]    edge_mask,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sag_pkg::FRAMES_W-1:0]  frame_index,
    output logic [sag_pkg::X_W-1:0]       frame_x,
    output logic [sag_pkg::SEL_W-1:0]     anim_current,
    output logic                          switched
);
    import sag_pkg::*;

    localparam int AW     = $clog2(NUM_ANIMS);
    localparam int EAW    = 2 * AW;
    localparam int MASK_W = (NUM_CONDS < FLAG_W) ? NUM_CONDS : FLAG_W;
    localparam int EDGE_W = MASK_W + 1;
    localparam logic [AW-1:0] LAST_ANIM = AW'(NUM_ANIMS - 1);

    // selector decode and table writes
    logic [AW-1:0]        sel_a;
    logic [AW-1:0]        tgt_a;
    logic                 sel_ok;
    logic                 tgt_ok;
    logic                 edge_ok;
    logic [NUM_ANIMS-1:0] user_written_reg;
    logic [EAW-1:0]       clr_cnt_reg;

    // running descriptor and visible state
    logic [FRAMES_W-1:0]  run_frames_reg;
    logic [PERIOD_W-1:0]  run_period_reg;
    logic                 run_loop_reg;
    logic                 run_rev_reg;
    logic [AW-1:0]        active_reg;
    logic [X_W-1:0]       source_x_reg;
    logic [FRAMES_W-1:0]  shown_reg;
    logic                 switched_reg;
    logic                 out_valid_reg;

    // per-tick work registers
    logic [NOW_W-1:0]     dvd_reg;
    logic [PERIOD_W-1:0]  rem_reg;
    logic [FRAMES_W:0]    r2_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [FRAMES_W-1:0]  factor_reg;
    logic [X_W-1:0]       last_x_reg;
    logic [MASK_W-1:0]    flags_reg;
    logic [AW-1:0]        scan_reg;
    logic [FRAMES_W-1:0]  out_frame_reg;
    logic [X_W-1:0]       out_x_reg;
    logic [SEL_W-1:0]     out_anim_reg;
    logic                 out_sw_reg;

    logic [FRAMES_W-1:0]  frames_eff;
    logic [FRAMES_W:0]    mod_m;
    logic [FRAMES_W-1:0]  mul_b;
    logic [X_W-1:0]       prod;
    logic [PERIOD_W:0]    rem_sh;
    logic                 q_bit;
    logic [PERIOD_W-1:0]  rem_next;
    logic [FRAMES_W+1:0]  r2_sh;
    logic [FRAMES_W:0]    r2_next;
    logic [FRAMES_W-1:0]  folded;

    logic                 edge_we;
    logic [EAW-1:0]       edge_waddr;
    logic [EDGE_W-1:0]    edge_wdata;
    logic [AW-1:0]        edge_rd_t;
    logic [EDGE_W-1:0]    edge_rdata;
    logic [DESC_W-1:0]    anim_rdata;
    logic [DESC_W-1:0]    new_desc;

    assign sel_a   = AW'(anim_sel);
    assign tgt_a   = AW'(target_sel);
    assign sel_ok  = 32'(anim_sel) < NUM_ANIMS;
    assign tgt_ok  = 32'(target_sel) < NUM_ANIMS;
    // entry 0 counts as written from reset
    assign edge_ok = sel_ok && tgt_ok
                     && (user_written_reg[sel_a] || (sel_a == '0))
                     && (user_written_reg[tgt_a] || (tgt_a == '0));

    assign edge_we    = cmd.clear_wr || (cmd.wr_edge && edge_ok);
    assign edge_waddr = cmd.clear_wr ? clr_cnt_reg : {sel_a, tgt_a};
    assign edge_wdata = cmd.clear_wr ? '0 : {1'b1, edge_mask[MASK_W-1:0]};
    assign edge_rd_t  = cmd.scan_step ? AW'(scan_reg + 1'b1) : '0;

    sag_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (1 << EAW)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr ({active_reg, edge_rd_t}),
        .rdata (edge_rdata)
    );

    sag_ram #(
        .WIDTH (DESC_W),
        .DEPTH (NUM_ANIMS)
    ) u_anim_ram (
        .clk   (clk),
        .we    (cmd.wr_anim && sel_ok),
        .waddr (sel_a),
        .wdata ({frame_count, frame_period, looping, reversible}),
        .raddr (scan_reg),
        .rdata (anim_rdata)
    );

    // entry 0 falls back to its preset until it is written
    assign new_desc = ((scan_reg == '0) && !user_written_reg[0])
                      ? {FRAMES_W'(1), PERIOD_W'(0), 1'b0, 1'b0}
                      : anim_rdata;

    assign frames_eff = (run_frames_reg == '0) ? FRAMES_W'(1) : run_frames_reg;
    assign mod_m      = {frames_eff, 1'b0};
    assign mul_b      = cmd.mulx ? factor_reg : frames_eff - 1'b1;
    assign prod       = {{(X_W-FW_W){1'b0}}, frame_width}
                        * {{(X_W-FRAMES_W){1'b0}}, mul_b};

    // restoring divide step; each quotient bit is folded into the
    // running remainder modulo 2*frames, MSB first
    assign rem_sh   = {rem_reg, dvd_reg[NOW_W-1]};
    assign q_bit    = rem_sh >= {1'b0, run_period_reg};
    assign rem_next = q_bit ? PERIOD_W'(rem_sh - {1'b0, run_period_reg})
                            : PERIOD_W'(rem_sh);
    assign r2_sh    = {r2_reg, q_bit};
    assign r2_next  = (r2_sh >= {1'b0, mod_m}) ? (FRAMES_W+1)'(r2_sh - {1'b0, mod_m})
                                               : (FRAMES_W+1)'(r2_sh);

    always_comb
    begin
        folded = FRAMES_W'(r2_reg);
        if (r2_reg >= {1'b0, frames_eff})
        begin
            folded = run_rev_reg ? FRAMES_W'(mod_m - 1'b1 - r2_reg)
                                 : FRAMES_W'(r2_reg - {1'b0, frames_eff});
        end
    end

    assign stat.clear_done  = &clr_cnt_reg;
    assign stat.advance     = run_loop_reg || (source_x_reg != last_x_reg);
    assign stat.period_zero = run_period_reg == '0;
    assign stat.div_last    = &div_cnt_reg;
    assign stat.edge_hit    = edge_rdata[MASK_W]
                              && ((edge_rdata[MASK_W-1:0] & ~flags_reg) == '0);
    assign stat.scan_last   = scan_reg == LAST_ANIM;
    assign stat.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_written_reg <= '0;
            clr_cnt_reg      <= '0;
            run_frames_reg   <= FRAMES_W'(1);
            run_period_reg   <= '0;
            run_loop_reg     <= 1'b0;
            run_rev_reg      <= 1'b0;
            active_reg       <= '0;
            source_x_reg     <= '0;
            shown_reg        <= '0;
            switched_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            div_cnt_reg      <= '0;
            scan_reg         <= '0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.wr_anim && sel_ok)
            begin
                user_written_reg[sel_a] <= 1'b1;
            end
            if (cmd.cap_tick)
            begin
                switched_reg <= 1'b0;
            end
            if (cmd.div_init)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.mulx)
            begin
                shown_reg    <= factor_reg;
                source_x_reg <= prod;
            end
            if (cmd.scan_start)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.take_edge)
            begin
                active_reg     <= scan_reg;
                run_frames_reg <= new_desc[DESC_W-1 -: FRAMES_W];
                run_period_reg <= new_desc[2 +: PERIOD_W];
                run_loop_reg   <= new_desc[1];
                run_rev_reg    <= new_desc[0];
                source_x_reg   <= '0;
                shown_reg      <= '0;
                switched_reg   <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_tick)
        begin
            dvd_reg   <= now_ms;
            flags_reg <= cond_flags[MASK_W-1:0];
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[NOW_W-2:0], 1'b0};
        end
        if (cmd.last_x_ld)
        begin
            last_x_reg <= prod;
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            r2_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            r2_reg  <= r2_next;
        end
        if (cmd.fold)
        begin
            factor_reg <= stat.period_zero ? '0 : folded;
        end
        if (cmd.load_out)
        begin
            out_frame_reg <= shown_reg;
            out_x_reg     <= source_x_reg;
            out_anim_reg  <= SEL_W'(active_reg);
            out_sw_reg    <= switched_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_index  = out_frame_reg;
    assign frame_x      = out_x_reg;
    assign anim_current = out_anim_reg;
    assign switched     = out_sw_reg;
endmodule

/* src/sprite_animation_graph_top.sv */
// Top level of the sprite animation graph: APB register, sequencer, datapath.
// Depends on sag_pkg, sag_in_if, sag_out_if, sag_ctrl and sag_dp.
//
//   Channel   Dir  Handshake               Carries
//   in_ch     in   valid/ready             tick, animation write or edge write
//   out_ch    out  valid/ready             frame index, x offset, animation, switched
//   APB       in   psel/penable/pwrite     frame_width at byte address 0
//
// A descriptor or edge write gives no result and leaves the sequencer idle.
// A tick runs from acceptance to result through the 64-step serial divider, when the
// frame advances with a nonzero period, and the one-edge-per-cycle scan of the edge
// RAM, which takes the first matching target; a held frame or a zero period skips
// the divider.
// After reset all 4**clog2(NUM_ANIMS) entries of the edge RAM (64 by default) are
// swept clear before the first item is taken.
// A result waiting on out_ch does not block input; a finished tick holds
// until the output register is free.
module sprite_animation_graph_top #(
    parameter int NUM_ANIMS = sag_pkg::NUM_ANIMS_DEF,
    parameter int NUM_CONDS = sag_pkg::NUM_CONDS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sag_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sag_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sag_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    sag_in_if.sink                            in_ch,
    sag_out_if.source                         out_ch
);
    import sag_pkg::*;

    logic [FW_W-1:0] frame_width_reg;
    reg_index_t      reg_idx;
    ctrl_cmd_t       cmd;
    ctrl_stat_t      stat;
    logic            in_ready;

    assign pready  = 1'b1;
    assign reg_idx = reg_index_t'(paddr[APB_ADDR_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FRAME_WIDTH_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                REG_FRAME_WIDTH: frame_width_reg <= pwdata[FW_W-1:0];
                default:         frame_width_reg <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_WIDTH: prdata = {{(APB_DATA_W-FW_W){1'b0}}, frame_width_reg};
            default:         prdata = '0;
        endcase
    end

    sag_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_kind  (in_ch.kind),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    assign in_ch.ready = in_ready;

    sag_dp #(
        .NUM_ANIMS (NUM_ANIMS),
        .NUM_CONDS (NUM_CONDS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .frame_width  (frame_width_reg),
        .now_ms       (in_ch.now_ms),
        .cond_flags   (in_ch.cond_flags),
        .anim_sel     (in_ch.anim_sel),
        .target_sel   (in_ch.target_sel),
        .frame_count  (in_ch.frame_count),
        .frame_period (in_ch.frame_period),
        .looping      (in_ch.looping),
        .reversible   (in_ch.reversible),
        .edge_mask    (in_ch.edge_mask),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .frame_index  (out_ch.frame_index),
        .frame_x      (out_ch.frame_x),
        .anim_current (out_ch.anim_current),
        .switched     (out_ch.switched)
    );
endmodule

/* src/sag_checker.sv */
// Port-level checks for the sprite animation graph, bound to the top level.
// Depends on sag_pkg and sprite_animation_graph_top.
module sag_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [sag_pkg::KIND_W-1:0]     in_kind,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [sag_pkg::FRAMES_W-1:0]   frame_index,
    input logic [sag_pkg::X_W-1:0]        frame_x,
    input logic [sag_pkg::SEL_W-1:0]      anim_current,
    input logic                           switched
);
    import sag_pkg::*;

    // a tick occupies the sequencer, so input closes for the next cycle
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_kind == KIND_TICK) |=> !in_ready)
        else $error("input still open after a tick was taken");

    // table writes and unknown kinds leave input open for the next cycle
    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_kind != KIND_TICK) |=> in_ready)
        else $error("input closed after a one-cycle item");

    // taking an edge restarts the strip at frame 0
    a_switch_reset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && switched |-> (frame_index == '0) && (frame_x == '0))
        else $error("switched result with nonzero frame");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_index)
            && $stable(frame_x) && $stable(anim_current) && $stable(switched))
        else $error("stalled result changed");
endmodule

bind sprite_animation_graph_top sag_checker u_sag_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_kind      (in_ch.kind),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .frame_index  (out_ch.frame_index),
    .frame_x      (out_ch.frame_x),
    .anim_current (out_ch.anim_current),
    .switched     (out_ch.switched)
);
